// File: sv/fckv_pkg.sv
// fckv_pkg: shared types and constants of the fixed-capacity key/value table
// used by fixed_capacity_key_value_table_unit; depends on nothing

package fckv_pkg;

  // table geometry
  localparam int CAPACITY   = 256;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 64;
  localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);

  // operation codes
  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_UPDATE  = 3'd1;
  localparam logic [2:0] OP_INS_UPD = 3'd2;
  localparam logic [2:0] OP_ERASE   = 3'd3;
  localparam logic [2:0] OP_LOOKUP  = 3'd4;
  localparam logic [2:0] OP_READ    = 3'd5;

  // request beat
  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] key;
    logic [63:0] value;
    logic [7:0]  position;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic        ok;
    logic [31:0] key_out;
    logic [63:0] value_out;
    logic [8:0]  entry_count;
  } out_beat_t;

  // one stored pair
  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

endpackage

// File: sv/fckv_ram.sv
// fckv_ram: generic simple dual-port ram, one write and one read port
// registered read data, no reset on contents; no package dependencies

module fckv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/fixed_capacity_key_value_table_unit.sv
// fixed_capacity_key_value_table_unit: top level of the ordered key/value table
// depends on fckv_pkg and fckv_ram
//
// usage
// - in channel: one request beat (operation, key, value, position) is taken when
//   in_valid is high and in_stall low; in_stall stays high while a request is
//   being worked on, so requests are handled one at a time
// - out channel: exactly one result beat per request (ok, key_out, value_out,
//   entry_count); out_valid holds with a steady payload while out_stall is high
// - pairs live in one ram, key and value side by side; the table stays packed
//   and in insertion order, erase moves later entries down by one
// - search ops read one entry per cycle from the start of the table until a hit
//   or the end of the packed entries
// - erase adds a copy pass behind the hit; read by position reads the ram first,
//   bad positions and unused codes go straight to the result; the next request
//   is taken in the cycle after the result is loaded
// - a new request is taken while the previous result still waits in the output
//   register; a finished result waits in its own state until that register frees
// - reset (rst_n low, synchronous) empties the table and drops any pending
//   result; ram contents are left as they are and never read before written

module fixed_capacity_key_value_table_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fckv_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fckv_pkg::out_beat_t out_data
);

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_READ   = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // control state
  logic [fckv_pkg::CNT_BITS-1:0] count_r, count_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          cmp_vld_r, cmp_vld_nxt;
  logic                          sh_wvld_r, sh_wvld_nxt;

  // request and scan bookkeeping
  logic [2:0]                      op_r, op_nxt;
  logic [fckv_pkg::KEY_BITS-1:0]   key_r, key_nxt;
  logic [fckv_pkg::VALUE_BITS-1:0] value_r, value_nxt;
  logic [fckv_pkg::CNT_BITS-1:0]   scan_idx_r, scan_idx_nxt;
  logic [fckv_pkg::IDX_BITS-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic [fckv_pkg::CNT_BITS-1:0]   sh_rd_r, sh_rd_nxt;
  logic [fckv_pkg::IDX_BITS-1:0]   sh_wa_r, sh_wa_nxt;

  // pending result
  logic                            res_ok_r, res_ok_nxt;
  logic [fckv_pkg::KEY_BITS-1:0]   res_key_r, res_key_nxt;
  logic [fckv_pkg::VALUE_BITS-1:0] res_value_r, res_value_nxt;
  fckv_pkg::out_beat_t             out_data_r, out_data_nxt;

  // ram port signals
  logic                          ram_we;
  logic [fckv_pkg::IDX_BITS-1:0] ram_waddr;
  fckv_pkg::entry_t              ram_wdata;
  logic                          ram_re;
  logic [fckv_pkg::IDX_BITS-1:0] ram_raddr;
  logic [$bits(fckv_pkg::entry_t)-1:0] ram_rdata;
  fckv_pkg::entry_t              rd_entry;

  logic hit;
  logic scan_more;
  logic full;

  fckv_ram #(
    .WIDTH ($bits(fckv_pkg::entry_t)),
    .DEPTH (fckv_pkg::CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign rd_entry  = fckv_pkg::entry_t'(ram_rdata);
  // compare the entry read in the previous cycle
  assign hit       = cmp_vld_r && (rd_entry.key == key_r);
  assign scan_more = scan_idx_r < count_r;
  assign full      = count_r == fckv_pkg::CNT_BITS'(fckv_pkg::CAPACITY);

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cmp_vld_nxt   = cmp_vld_r;
    sh_wvld_nxt   = sh_wvld_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    value_nxt     = value_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    sh_rd_nxt     = sh_rd_r;
    sh_wa_nxt     = sh_wa_r;
    res_ok_nxt    = res_ok_r;
    res_key_nxt   = res_key_r;
    res_value_nxt = res_value_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt        = in_data.operation;
          key_nxt       = in_data.key;
          value_nxt     = in_data.value;
          scan_idx_nxt  = '0;
          cmp_vld_nxt   = 1'b0;
          res_ok_nxt    = 1'b0;
          res_key_nxt   = '0;
          res_value_nxt = '0;
          unique case (in_data.operation) inside
            fckv_pkg::OP_INSERT, fckv_pkg::OP_UPDATE, fckv_pkg::OP_INS_UPD,
            fckv_pkg::OP_ERASE, fckv_pkg::OP_LOOKUP: begin
              state_nxt = S_SEARCH;
            end
            fckv_pkg::OP_READ: begin
              if (fckv_pkg::CNT_BITS'(in_data.position) < count_r) begin
                ram_re    = 1'b1;
                ram_raddr = fckv_pkg::IDX_BITS'(in_data.position);
                state_nxt = S_READ;
              end else begin
                state_nxt = S_RESULT;
              end
            end
            default: begin
              state_nxt = S_RESULT;
            end
          endcase
        end
      end

      S_SEARCH: begin
        cmp_vld_nxt = 1'b0;
        if (hit) begin
          unique case (op_r) inside
            fckv_pkg::OP_UPDATE, fckv_pkg::OP_INS_UPD: begin
              ram_we     = 1'b1;
              ram_waddr  = cmp_idx_r;
              ram_wdata  = '{key: key_r, value: value_r};
              res_ok_nxt = 1'b1;
              state_nxt  = S_RESULT;
            end
            fckv_pkg::OP_ERASE: begin
              sh_rd_nxt   = fckv_pkg::CNT_BITS'(cmp_idx_r) + fckv_pkg::CNT_BITS'(1);
              sh_wvld_nxt = 1'b0;
              state_nxt   = S_SHIFT;
            end
            fckv_pkg::OP_LOOKUP: begin
              res_ok_nxt    = 1'b1;
              res_value_nxt = rd_entry.value;
              state_nxt     = S_RESULT;
            end
            default: begin
              // duplicate insert
              state_nxt = S_RESULT;
            end
          endcase
        end else if (scan_more) begin
          ram_re       = 1'b1;
          ram_raddr    = scan_idx_r[fckv_pkg::IDX_BITS-1:0];
          cmp_idx_nxt  = scan_idx_r[fckv_pkg::IDX_BITS-1:0];
          scan_idx_nxt = scan_idx_r + fckv_pkg::CNT_BITS'(1);
          cmp_vld_nxt  = 1'b1;
        end else begin
          // key absent: append when allowed
          state_nxt = S_RESULT;
          if ((op_r == fckv_pkg::OP_INSERT || op_r == fckv_pkg::OP_INS_UPD) && !full) begin
            ram_we     = 1'b1;
            ram_waddr  = count_r[fckv_pkg::IDX_BITS-1:0];
            ram_wdata  = '{key: key_r, value: value_r};
            count_nxt  = count_r + fckv_pkg::CNT_BITS'(1);
            res_ok_nxt = 1'b1;
          end
        end
      end

      S_SHIFT: begin
        // read entry j+1 while writing entry j, read last cycle, down to j-1
        sh_wvld_nxt = 1'b0;
        if (sh_wvld_r) begin
          ram_we    = 1'b1;
          ram_waddr = sh_wa_r;
          ram_wdata = rd_entry;
        end
        if (sh_rd_r < count_r) begin
          ram_re      = 1'b1;
          ram_raddr   = sh_rd_r[fckv_pkg::IDX_BITS-1:0];
          sh_wa_nxt   = fckv_pkg::IDX_BITS'(sh_rd_r - fckv_pkg::CNT_BITS'(1));
          sh_rd_nxt   = sh_rd_r + fckv_pkg::CNT_BITS'(1);
          sh_wvld_nxt = 1'b1;
        end else if (!sh_wvld_r) begin
          count_nxt  = count_r - fckv_pkg::CNT_BITS'(1);
          res_ok_nxt = 1'b1;
          state_nxt  = S_RESULT;
        end
      end

      S_READ: begin
        res_ok_nxt    = 1'b1;
        res_key_nxt   = rd_entry.key;
        res_value_nxt = rd_entry.value;
        state_nxt     = S_RESULT;
      end

      S_RESULT: begin
        // hand over once the output register is free or being drained
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.ok          = res_ok_r;
          out_data_nxt.key_out     = 32'(res_key_r);
          out_data_nxt.value_out   = 64'(res_value_r);
          out_data_nxt.entry_count = 9'(count_r);
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
      sh_wvld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      sh_wvld_r   <= sh_wvld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    value_r     <= value_nxt;
    scan_idx_r  <= scan_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    sh_rd_r     <= sh_rd_nxt;
    sh_wa_r     <= sh_wa_nxt;
    res_ok_r    <= res_ok_nxt;
    res_key_r   <= res_key_nxt;
    res_value_r <= res_value_nxt;
    out_data_r  <= out_data_nxt;
  end

  // the entry count never goes past the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= fckv_pkg::CNT_BITS'(fckv_pkg::CAPACITY))
    else $error("entry count above capacity");

  // writes stay inside the packed region or append right behind it
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (fckv_pkg::CNT_BITS'(ram_waddr) < count_r ||
                (fckv_pkg::CNT_BITS'(ram_waddr) == count_r && !full)))
    else $error("ram write outside the packed table");

  // one request moves the count by at most one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && count_r != $past(count_r) |->
      (count_r == $past(count_r) + fckv_pkg::CNT_BITS'(1) ||
       count_r + fckv_pkg::CNT_BITS'(1) == $past(count_r)))
    else $error("entry count jumped");

  // the count only changes when a search or an erase pass finishes
  a_count_src: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != count_nxt |-> (state_r == S_SEARCH || state_r == S_SHIFT))
    else $error("entry count changed outside search or erase");

endmodule
